>>> rtl/core/cce_pkg.sv
// cce_pkg: types, codes and constants shared by the coefficient command echo
// used by cce_ctrl, cce_dp and coefficient_command_echo; no dependencies

package cce_pkg;

  // command characters
  localparam logic [7:0] CMD_SHOW    = 8'h73;  // 's'
  localparam logic [7:0] CMD_SET     = 8'h72;  // 'r'
  localparam logic [7:0] CMD_PERSIST = 8'h65;  // 'e'

  localparam int          IDX_W      = 3;
  localparam int          VAL_W      = 14;
  localparam int          LOC_W      = 11;
  localparam int          COEF_COUNT_DEFAULT = 8;

  localparam logic [VAL_W-1:0] VALUE_MAX  = 14'd9999;
  localparam logic [VAL_W-1:0] DIGIT_STEP = 14'd1000;
  localparam logic [7:0]       ASCII_ZERO = 8'd48;
  localparam logic [7:0]       TAB_BYTE   = 8'h09;

  // byte positions inside one shown record
  localparam logic [2:0] POS_ID_FIRST  = 3'd0;
  localparam logic [2:0] POS_ID_SECOND = 3'd1;
  localparam logic [2:0] POS_TAB       = 3'd6;

  typedef struct packed {
    logic [7:0]       command;
    logic [7:0]       id_first;
    logic [7:0]       id_second;
    logic [IDX_W-1:0] coefficient_index;
    logic [VAL_W-1:0] new_value;
    logic [LOC_W-1:0] store_location;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]       tx_byte;
    logic             byte_valid;
    logic             last;
    logic             accepted;
    logic             store_request;
    logic [LOC_W-1:0] store_address;
    logic [VAL_W-1:0] store_value;
  } res_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_REJECT
  } state_t;

  typedef enum logic [2:0] {
    SEL_ID_FIRST,
    SEL_ID_SECOND,
    SEL_DIGIT,
    SEL_TAB,
    SEL_NONE
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      load;
    logic      emit;
    logic      reject;
    logic      first;
    logic      last;
    byte_sel_t sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic known;
    logic slot_free;
  } dp_stat_t;

endpackage

>>> rtl/core/cce_ctrl.sv
// cce_ctrl: sequencing state machine for the coefficient command echo
// depends on cce_pkg

module cce_ctrl
  import cce_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= POS_ID_FIRST;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd_stall   = 1'b1;
    ctl         = '0;
    ctl.sel     = SEL_NONE;
    case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.load   = 1'b1;
        cnt_next   = POS_ID_FIRST;
        state_next = stat.known ? ST_EMIT : ST_REJECT;
      end
      ST_EMIT: begin
        case (cnt)
          POS_ID_FIRST:  ctl.sel = SEL_ID_FIRST;
          POS_ID_SECOND: ctl.sel = SEL_ID_SECOND;
          POS_TAB:       ctl.sel = SEL_TAB;
          default:       ctl.sel = SEL_DIGIT;
        endcase
        ctl.first = (cnt == POS_ID_FIRST);
        ctl.last  = (cnt == POS_TAB);
        if (stat.slot_free) begin
          ctl.emit = 1'b1;
          if (cnt == POS_TAB) begin
            cnt_next   = POS_ID_FIRST;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      ST_REJECT: begin
        ctl.reject = 1'b1;
        ctl.last   = 1'b1;
        if (stat.slot_free) begin
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/cce_dp.sv
// cce_dp: coefficient table, digit unit and result register
// depends on cce_pkg

module cce_dp
  import cce_pkg::*;
#(
  parameter int COEF_COUNT = COEF_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_item_t cmd,
  input  dp_cmd_t   ctl,
  output dp_stat_t  stat,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  // only indexes the 3-bit field can reach are stored
  localparam int TabDepth = (COEF_COUNT < (1 << IDX_W)) ? COEF_COUNT : (1 << IDX_W);
  localparam int AW       = (TabDepth > 1) ? $clog2(TabDepth) : 1;

  logic [VAL_W-1:0] mem [TabDepth];
  logic [TabDepth-1:0] written;

  logic [AW-1:0]    addr;
  logic             in_range;
  logic             is_write;
  logic [VAL_W-1:0] sat_value;

  // captured command
  logic [7:0]       id_first, id_second;
  logic [LOC_W-1:0] location;
  logic [VAL_W-1:0] value;
  logic             known, is_show, persist, hit;
  logic [VAL_W-1:0] rd_data;

  // digit unit
  logic [VAL_W-1:0] work;
  logic [3:0]       digit;
  logic [VAL_W-1:0] rem, work_next;

  res_item_t        res_next;

  assign addr      = cmd.coefficient_index[AW-1:0];
  assign in_range  = 32'(cmd.coefficient_index) < 32'(COEF_COUNT);
  assign is_write  = ctl.capture && in_range &&
                     (cmd.command == CMD_SET || cmd.command == CMD_PERSIST);
  assign sat_value = (cmd.new_value > VALUE_MAX) ? VALUE_MAX : cmd.new_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (is_write) begin
      written[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[addr] <= sat_value;
    end
    if (ctl.capture) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      id_first  <= cmd.id_first;
      id_second <= cmd.id_second;
      location  <= cmd.store_location;
      value     <= sat_value;
      known     <= cmd.command == CMD_SHOW || cmd.command == CMD_SET ||
                   cmd.command == CMD_PERSIST;
      is_show   <= cmd.command == CMD_SHOW;
      persist   <= cmd.command == CMD_PERSIST;
      hit       <= in_range && written[addr];
    end
  end

  // one decimal digit per step: count thousands, then scale the remainder by ten
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (work >= VAL_W'(k * 1000)) digit = 4'(k);
    end
    rem       = work - VAL_W'(digit * DIGIT_STEP);
    work_next = (rem << 3) + (rem << 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= is_show ? (hit ? rd_data : '0) : value;
    end else if (ctl.emit && ctl.sel == SEL_DIGIT) begin
      work <= work_next;
    end
  end

  // result register
  assign stat.slot_free = !res_valid || !res_stall;
  assign stat.known     = known;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    res_next      = '0;
    res_next.last = ctl.last;
    if (!ctl.reject) begin
      res_next.byte_valid = 1'b1;
      res_next.accepted   = 1'b1;
      case (ctl.sel)
        SEL_ID_FIRST:  res_next.tx_byte = id_first;
        SEL_ID_SECOND: res_next.tx_byte = id_second;
        SEL_DIGIT:     res_next.tx_byte = ASCII_ZERO + {4'd0, digit};
        SEL_TAB:       res_next.tx_byte = TAB_BYTE;
        default:       res_next.tx_byte = '0;
      endcase
      if (persist && ctl.first) begin
        res_next.store_request = 1'b1;
        res_next.store_address = location;
        res_next.store_value   = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/core/coefficient_command_echo.sv
// coefficient_command_echo: top level of the tuning-command echo block
// depends on cce_pkg, cce_ctrl and cce_dp
//
//  channel | valid     | stall     | payload          | direction
//  --------+-----------+-----------+------------------+----------
//  command | cmd_valid | cmd_stall | cmd (cmd_item_t) | in
//  result  | res_valid | res_stall | res (res_item_t) | out
//
// a command transfer is taken only while the controller is idle; a known
// command then passes a load state and seven byte transfers, an unknown
// command a load state and a single rejection transfer. the rate is set by
// the single result register, which carries one byte per cycle while the
// result side does not stall, and the shared digit unit, one digit a step.
// reset clears the controller, the result valid and the table's written bits,
// so every coefficient reads zero at once. stalls on the result side hold the
// result register and pause the byte sequence; the last byte may still wait
// while the next command is taken.

module coefficient_command_echo
  import cce_pkg::*;
#(
  parameter int COEF_COUNT = COEF_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  dp_cmd_t  ctl;   // controller commands to the datapath
  dp_stat_t stat;  // datapath status back to the controller

  // sequencer: accept, table read, byte sequence
  cce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // table, digit unit and result register
  cce_dp #(
    .COEF_COUNT (COEF_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // a taken command keeps the input side stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command side not stalled after a transfer");

  // a store request only rides on a real, accepted byte
  a_store_on_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.store_request |-> res.accepted && res.byte_valid)
    else $error("store request on a result without a byte");

  // store fields are zero whenever no request is raised
  a_store_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.store_request |-> res.store_address == '0 && res.store_value == '0)
    else $error("store fields set without a request");

  // a result with no byte is the single rejection item
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.byte_valid |-> res.last && !res.accepted && res.tx_byte == '0)
    else $error("malformed rejection result");

endmodule

>>> bench/tb_coefficient_command_echo.sv
// tb_coefficient_command_echo: self-checking bench for the coefficient command echo
// depends on cce_pkg and coefficient_command_echo; a queue-fed driver, a monitor
// and an in-bench shadow of the coefficient table that predicts every echoed byte
`timescale 1ns / 100ps

module tb_coefficient_command_echo;
  import cce_pkg::*;

  localparam int COEF_SLOTS  = COEF_COUNT_DEFAULT;
  localparam int ECHO_LEN    = 7;     // id, id, four digits, tab
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int TAIL_CYCLES = 20;    // settle time once nothing is due
  localparam int QUIET_LIMIT = 1000;  // cycles with no transfer before giving up
  localparam int RANDOM_PER_PHASE = 24;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  // commands waiting to be offered, and result transfers still owed by the block
  cmd_item_t command_backlog[$];
  res_item_t echo_due[$];

  // shadow of the block's coefficient table, cleared by the one reset
  logic [VAL_W-1:0] coef_shadow [COEF_SLOTS] = '{default: '0};

  // idling percentages for the current phase, set by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // long hold-off: asked for by the stimulus, counted down by the monitor
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  int faults = 0;
  int quiet_cycles = 0;

  coefficient_command_echo #(
    .COEF_COUNT(COEF_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // works out the result transfers one accepted command causes and queues them;
  // a set or persist also updates the shadow table
  task automatic compute_echo(input cmd_item_t c);
    int               value;
    int               shown;
    logic             known;
    logic             persist;
    logic             in_range;
    logic [7:0]       echo_bytes [ECHO_LEN];
    res_item_t        r;
    value    = (c.new_value > VALUE_MAX) ? int'(VALUE_MAX) : int'(c.new_value);
    in_range = int'(c.coefficient_index) < COEF_SLOTS;
    known    = 1'b1;
    persist  = 1'b0;
    shown    = 0;
    case (c.command)
      CMD_SHOW: begin
        shown = in_range ? int'(coef_shadow[c.coefficient_index]) : 0;
      end
      CMD_SET, CMD_PERSIST: begin
        if (in_range) coef_shadow[c.coefficient_index] = VAL_W'(value);
        shown   = value;
        persist = (c.command == CMD_PERSIST);
      end
      default: known = 1'b0;
    endcase
    if (!known) begin
      // unknown command: a single empty transfer, marked not accepted
      r      = '0;
      r.last = 1'b1;
      echo_due.push_back(r);
    end else begin
      if (shown > int'(VALUE_MAX)) shown = int'(VALUE_MAX);
      echo_bytes[0] = c.id_first;
      echo_bytes[1] = c.id_second;
      echo_bytes[2] = ASCII_ZERO + 8'(shown / 1000);
      echo_bytes[3] = ASCII_ZERO + 8'((shown % 1000) / 100);
      echo_bytes[4] = ASCII_ZERO + 8'((shown % 100) / 10);
      echo_bytes[5] = ASCII_ZERO + 8'(shown % 10);
      echo_bytes[6] = TAB_BYTE;
      for (int k = 0; k < ECHO_LEN; k++) begin
        r            = '0;
        r.tx_byte    = echo_bytes[k];
        r.byte_valid = 1'b1;
        r.last       = (k == ECHO_LEN - 1);
        r.accepted   = 1'b1;
        // the store request rides on the first byte of a persist only
        if (persist && k == 0) begin
          r.store_request = 1'b1;
          r.store_address = c.store_location;
          r.store_value   = VAL_W'(value);
        end
        echo_due.push_back(r);
      end
    end
  endtask

  // compares one result transfer with the oldest one still due
  task automatic check_echo(input res_item_t got);
    res_item_t want;
    if (echo_due.size() == 0) begin
      $display("%0t: result with nothing due, expected none, actual %0h", $time, got);
      faults++;
    end else begin
      want = echo_due.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch, expected %0h, actual %0h", $time, want, got);
        faults++;
      end
    end
  endtask

  // driver: predicts on each command transfer, then offers the next queued
  // command unless this cycle is an idle one; a stalled command is held as is
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) compute_echo(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd       <= command_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and picks the stall for the next cycle;
  // a requested hold-off keeps the result side stalled for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) check_echo(res);
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        res_stall  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog: a long run with no transfer on either side means a hang
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic [7:0] op, input logic [7:0] id1,
                           input logic [7:0] id2, input int idx, input int value,
                           input int loc);
    cmd_item_t c;
    c.command           = op;
    c.id_first          = id1;
    c.id_second         = id2;
    c.coefficient_index = IDX_W'(idx);
    c.new_value         = VAL_W'(value);
    c.store_location    = LOC_W'(loc);
    command_backlog.push_back(c);
  endtask

  // mostly well-formed commands with random content, some near-miss and
  // random bytes that the block must reject
  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      c.command = CMD_SHOW;
    else if (pick < 55) c.command = CMD_SET;
    else if (pick < 82) c.command = CMD_PERSIST;
    else begin
      case ($urandom_range(5))
        0:       c.command = 8'h53;  // upper-case show
        1:       c.command = 8'h52;  // upper-case set
        2:       c.command = 8'h45;  // upper-case persist
        3:       c.command = CMD_SHOW + 8'd1;
        default: c.command = 8'($urandom_range(255));
      endcase
    end
    c.id_first          = 8'($urandom_range(255));
    c.id_second         = 8'($urandom_range(255));
    c.coefficient_index = IDX_W'($urandom_range(COEF_SLOTS - 1));
    case ($urandom_range(9))
      0:       c.new_value = '0;
      1:       c.new_value = VALUE_MAX;
      2:       c.new_value = VAL_W'($urandom_range(16383, 10000));  // saturates
      3:       c.new_value = VAL_W'($urandom_range(9));
      default: c.new_value = VAL_W'($urandom_range(9999));
    endcase
    c.store_location = LOC_W'($urandom_range(2047));
    return c;
  endfunction

  // pause the sender until every queued command has gone and every result is in
  task automatic wait_drained();
    while (command_backlog.size() != 0 || cmd_valid || echo_due.size() != 0)
      @(negedge clk);
  endtask

  // stimulus: reset, directed commands, then random phases with varied idling
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset contents, extremes of every field, saturation,
    // every command and a spread of unknown command bytes
    queue_cmd(CMD_SHOW,    8'h00, 8'hFF, 0, 0,     0);     // table reads zero after reset
    queue_cmd(CMD_SET,     8'hFF, 8'h00, 7, 9999,  2047);
    queue_cmd(CMD_SHOW,    8'h4B, 8'h50, 7, 16383, 2047);  // value field ignored on show
    queue_cmd(CMD_PERSIST, 8'h4B, 8'h49, 0, 0,     2047);
    queue_cmd(CMD_PERSIST, 8'h4B, 8'h44, 3, 16383, 0);     // saturates to the maximum
    queue_cmd(CMD_SHOW,    8'h4B, 8'h44, 3, 0,     0);
    queue_cmd(CMD_SET,     8'h41, 8'h42, 1, 10000, 1);     // just above the maximum
    queue_cmd(CMD_SET,     8'h55, 8'hAA, 2, 1234,  1024);
    queue_cmd(CMD_SHOW,    8'hAA, 8'h55, 2, 8191,  1023);
    queue_cmd(CMD_PERSIST, 8'h01, 8'h80, 5, 5678,  'h555);
    queue_cmd(CMD_PERSIST, 8'h7F, 8'hFE, 6, 8191,  'h2AA);
    queue_cmd(CMD_SHOW,    8'h30, 8'h39, 6, 0,     0);
    queue_cmd(8'h00,       8'hFF, 8'hFF, 7, 16383, 2047);  // unknown, every other field high
    queue_cmd(8'hFF,       8'h00, 8'h00, 0, 0,     0);
    queue_cmd(8'h53,       8'h12, 8'h34, 1, 100,   5);
    queue_cmd(8'h52,       8'h56, 8'h78, 2, 200,   6);
    queue_cmd(8'h45,       8'h9A, 8'hBC, 3, 300,   7);
    queue_cmd(CMD_SHOW + 8'd1, 8'hDE, 8'hF0, 4, 400, 8);
    queue_cmd(CMD_SET,     8'h20, 8'h09, 4, 1,     0);
    queue_cmd(CMD_SHOW,    8'h09, 8'h20, 4, 0,     0);
    queue_cmd(CMD_SET,     8'h61, 8'h62, 0, 9990,  0);
    queue_cmd(CMD_SHOW,    8'h62, 8'h61, 0, 0,     0);
    queue_cmd(CMD_SHOW,    8'h63, 8'h64, 1, 0,     0);     // saturated set reads back
    wait_drained();

    // random phases; the first also holds the result side off for a long
    // stretch while commands keep coming, so the block fills and stalls
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_go = 1'b1; end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (RANDOM_PER_PHASE) command_backlog.push_back(random_command());
      wait_drained();
    end

    // nothing is due any more; any stray result in the tail is flagged
    repeat (TAIL_CYCLES) @(negedge clk);
    if (faults == 0 && echo_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cce_pkg.sv
rtl/core/cce_ctrl.sv
rtl/core/cce_dp.sv
rtl/core/coefficient_command_echo.sv
bench/tb_coefficient_command_echo.sv
